/* design/priority_preemptive_round_robin_unit_macros.svh */
// Assertion macros used by the scheduler datapath.
// Unless ASSERT_OFF is defined, each use expands to one labeled concurrent assertion that reports by $error.
`ifndef PRIORITY_PREEMPTIVE_ROUND_ROBIN_UNIT_MACROS_SVH
`define PRIORITY_PREEMPTIVE_ROUND_ROBIN_UNIT_MACROS_SVH

`ifndef ASSERT_OFF
`define PPR_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("scheduler assertion failed");
`define PPR_ASSERT_NEVER(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("scheduler reached a forbidden condition");
`else
`define PPR_ASSERT(label, clk, rst, prop)
`define PPR_ASSERT_NEVER(label, clk, rst, expr)
`endif

`endif

/* design/ppr_pkg.sv */
`timescale 1ns / 1ps

package ppr_pkg;

   localparam int MAX_PROCESSES = 16;
   localparam int IDX_W = $clog2(MAX_PROCESSES);
   localparam int CNT_W = $clog2(MAX_PROCESSES + 1);

   localparam int OP_W      = 2;
   localparam int TIME_W    = 16;
   localparam int BURST_W   = 16;
   localparam int PRIO_W    = 8;
   localparam int PID_W     = 4;
   localparam int STATUS_W  = 3;
   localparam int QUANTUM_W = 8;

   localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(MAX_PROCESSES);

   // Request operations.
   localparam logic [OP_W-1:0] OP_LOAD  = 2'd0;
   localparam logic [OP_W-1:0] OP_TICK  = 2'd1;
   localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

   // Result status codes.
   localparam logic [STATUS_W-1:0] ST_LOADED   = 3'd0;
   localparam logic [STATUS_W-1:0] ST_REJECTED = 3'd1;
   localparam logic [STATUS_W-1:0] ST_RAN      = 3'd2;
   localparam logic [STATUS_W-1:0] ST_IDLE     = 3'd3;
   localparam logic [STATUS_W-1:0] ST_CLEARED  = 3'd4;

   typedef struct packed {
      logic [TIME_W-1:0]  arrival;
      logic [BURST_W-1:0] remaining;
      logic [PRIO_W-1:0]  priority_level;
      logic [PID_W-1:0]   id;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   typedef struct packed {
      logic [OP_W-1:0]    operation;
      logic [TIME_W-1:0]  arrival_time;
      logic [BURST_W-1:0] burst_length;
      logic [PRIO_W-1:0]  priority_level;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [PID_W-1:0]    process_id;
      logic                finished;
      logic [TIME_W-1:0]   time_now;
      logic                all_done;
   } rsp_type;

   typedef struct packed {
      logic accept;
      logic load_read;
      logic load_shift;
      logic load_insert;
      logic scan_step;
      logic update;
      logic rot_step;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic table_full;
      logic pos_zero;
      logic load_stop;
      logic scan_done;
      logic rotate;
      logic rot_done;
      logic rsp_free;
   } stat_type;

   // Load-order id: the table count taken modulo the id range.
   function automatic logic [PID_W-1:0] pid_of(input logic [CNT_W-1:0] count);
      return PID_W'(count);
   endfunction

   function automatic logic [CNT_W-1:0] next_index(input logic [IDX_W-1:0] index);
      return CNT_W'(index) + 1'b1;
   endfunction

endpackage

/* design/ppr_req_if.sv */
`timescale 1ns / 1ps

interface ppr_req_if;
   logic                          valid;
   logic                          ready;
   logic [ppr_pkg::OP_W-1:0]      operation;
   logic [ppr_pkg::TIME_W-1:0]    arrival_time;
   logic [ppr_pkg::BURST_W-1:0]   burst_length;
   logic [ppr_pkg::PRIO_W-1:0]    priority_level;

   modport source (output valid, output operation, output arrival_time,
                   output burst_length, output priority_level, input ready);
   modport sink (input valid, input operation, input arrival_time,
                 input burst_length, input priority_level, output ready);
endinterface

/* design/ppr_rsp_if.sv */
`timescale 1ns / 1ps

interface ppr_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [ppr_pkg::STATUS_W-1:0]   status;
   logic [ppr_pkg::PID_W-1:0]      process_id;
   logic                           finished;
   logic [ppr_pkg::TIME_W-1:0]     time_now;
   logic                           all_done;

   modport source (output valid, output status, output process_id, output finished,
                   output time_now, output all_done, input ready);
   modport sink (input valid, input status, input process_id, input finished,
                 input time_now, input all_done, output ready);
endinterface

/* design/ppr_csr_if.sv */
`timescale 1ns / 1ps

interface ppr_csr_if;
   logic                            valid;
   logic                            ready;
   logic [ppr_pkg::QUANTUM_W-1:0]   quantum;

   modport source (output valid, output quantum, input ready);
   modport sink (input valid, input quantum, output ready);
endinterface

/* design/priority_preemptive_round_robin_unit.sv */
`timescale 1ns / 1ps
// Channel | Direction | Moves
// req_ch  | in        | request: operation, arrival_time, burst_length, priority_level
// rsp_ch  | out       | one result per request: status, process_id, finished, time_now, all_done
// csr_ch  | in        | quantum register write, always ready
//
// One request is worked at a time; the result register lets the next request in while
// the previous result waits. Between accepting a request and loading its result, a load
// walks down from the table end and moves each entry that arrived later up one slot; a
// tick scans every entry and, when the process rotates, moves the entries after its slot
// down one and puts it at the table end; clear or reject goes straight to the result.
// Reset is synchronous and empties the table; a stalled result holds the next one back.

module priority_preemptive_round_robin_unit (
   input logic       clock,
   input logic       reset,
   ppr_req_if.sink   req_ch,
   ppr_rsp_if.source rsp_ch,
   ppr_csr_if.sink   csr_ch
);

   ppr_pkg::cmd_type  cmd;
   ppr_pkg::stat_type stat;
   ppr_pkg::req_type  req_payload;
   ppr_pkg::rsp_type  rsp_payload;
   logic              req_ready;
   logic              rsp_valid;
   logic              csr_ready;

   always_comb begin
      req_payload.operation      = req_ch.operation;
      req_payload.arrival_time   = req_ch.arrival_time;
      req_payload.burst_length   = req_ch.burst_length;
      req_payload.priority_level = req_ch.priority_level;
   end

   ppr_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_ch.valid),
      .req_operation (req_ch.operation),
      .stat          (stat),
      .req_ready     (req_ready),
      .cmd           (cmd)
   );

   ppr_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_in      (req_payload),
      .cmd         (cmd),
      .stat        (stat),
      .csr_valid   (csr_ch.valid),
      .csr_quantum (csr_ch.quantum),
      .csr_ready   (csr_ready),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ch.ready),
      .rsp_out     (rsp_payload)
   );

   assign req_ch.ready      = req_ready;
   assign csr_ch.ready      = csr_ready;
   assign rsp_ch.valid      = rsp_valid;
   assign rsp_ch.status     = rsp_payload.status;
   assign rsp_ch.process_id = rsp_payload.process_id;
   assign rsp_ch.finished   = rsp_payload.finished;
   assign rsp_ch.time_now   = rsp_payload.time_now;
   assign rsp_ch.all_done   = rsp_payload.all_done;

endmodule

/* design/ppr_ram.sv */
`timescale 1ns / 1ps

module ppr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* design/ppr_ctrl.sv */
`timescale 1ns / 1ps

module ppr_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  logic [ppr_pkg::OP_W-1:0] req_operation,
   input  ppr_pkg::stat_type        stat,
   output logic                     req_ready,
   output ppr_pkg::cmd_type         cmd
);

   typedef enum logic [6:0] {
      S_IDLE     = 7'b0000001,
      S_LOAD_RD  = 7'b0000010,
      S_LOAD_CMP = 7'b0000100,
      S_SCAN     = 7'b0001000,
      S_UPDATE   = 7'b0010000,
      S_ROTATE   = 7'b0100000,
      S_RESULT   = 7'b1000000
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept = 1'b1;
               case (req_operation)
                  ppr_pkg::OP_LOAD: begin
                     state_in = stat.table_full ? S_RESULT : S_LOAD_RD;
                  end
                  ppr_pkg::OP_TICK: begin
                     state_in = S_SCAN;
                  end
                  default: begin
                     state_in = S_RESULT;
                  end
               endcase
            end
         end
         S_LOAD_RD: begin
            // Walk down from the table end; at the bottom the new entry goes in.
            if (stat.pos_zero) begin
               cmd.load_insert = 1'b1;
               state_in        = S_RESULT;
            end else begin
               cmd.load_read = 1'b1;
               state_in      = S_LOAD_CMP;
            end
         end
         S_LOAD_CMP: begin
            if (stat.load_stop) begin
               cmd.load_insert = 1'b1;
               state_in        = S_RESULT;
            end else begin
               cmd.load_shift = 1'b1;
               state_in       = S_LOAD_RD;
            end
         end
         S_SCAN: begin
            cmd.scan_step = 1'b1;
            if (stat.scan_done) begin
               state_in = S_UPDATE;
            end
         end
         S_UPDATE: begin
            cmd.update = 1'b1;
            state_in   = stat.rotate ? S_ROTATE : S_RESULT;
         end
         S_ROTATE: begin
            cmd.rot_step = 1'b1;
            if (stat.rot_done) begin
               state_in = S_RESULT;
            end
         end
         S_RESULT: begin
            if (stat.rsp_free) begin
               cmd.finish = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

/* design/ppr_datapath.sv */
`timescale 1ns / 1ps
`include "priority_preemptive_round_robin_unit_macros.svh"

module ppr_datapath (
   input  logic                          clock,
   input  logic                          reset,
   input  ppr_pkg::req_type              req_in,
   input  ppr_pkg::cmd_type              cmd,
   output ppr_pkg::stat_type             stat,
   input  logic                          csr_valid,
   input  logic [ppr_pkg::QUANTUM_W-1:0] csr_quantum,
   output logic                          csr_ready,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output ppr_pkg::rsp_type              rsp_out
);

   // Process table.
   ppr_pkg::entry_type               rd_entry;
   ppr_pkg::entry_type               wr_entry;
   ppr_pkg::entry_type               new_entry;
   ppr_pkg::entry_type               updated_entry;
   logic [ppr_pkg::IDX_W-1:0]        rd_addr;
   logic [ppr_pkg::IDX_W-1:0]        wr_addr;
   logic                             wr_en;

   // Control state.
   logic [ppr_pkg::CNT_W-1:0]        count_ff;
   logic [ppr_pkg::CNT_W-1:0]        pending_ff;
   logic [ppr_pkg::CNT_W-1:0]        idx_ff;
   logic [ppr_pkg::IDX_W-1:0]        cmp_idx_ff;
   logic                             cmp_valid_ff;
   logic [ppr_pkg::TIME_W-1:0]       time_ff;
   logic [ppr_pkg::PRIO_W-1:0]       tracked_ff;
   logic [ppr_pkg::PID_W-1:0]        last_id_ff;
   logic                             last_valid_ff;
   logic [ppr_pkg::QUANTUM_W-1:0]    run_ff;
   logic [ppr_pkg::QUANTUM_W-1:0]    quantum_ff;
   logic                             found1_ff;
   logic                             found2_ff;
   logic                             rsp_valid_ff;

   // Payload state.
   ppr_pkg::req_type                 req_ff;
   ppr_pkg::rsp_type                 res_ff;
   ppr_pkg::rsp_type                 rsp_ff;
   ppr_pkg::entry_type               cand1_ff;
   ppr_pkg::entry_type               cand2_ff;
   ppr_pkg::entry_type               held_ff;
   logic [ppr_pkg::IDX_W-1:0]        cand1_idx_ff;
   logic [ppr_pkg::IDX_W-1:0]        cand2_idx_ff;
   logic [ppr_pkg::PRIO_W-1:0]       best_level_ff;

   // Tick decision.
   logic [ppr_pkg::CNT_W-1:0]        idx_dec;
   logic [ppr_pkg::CNT_W-1:0]        count_dec;
   logic                             scan_more;
   logic                             eligible;
   logic                             found;
   ppr_pkg::entry_type               chosen;
   logic [ppr_pkg::IDX_W-1:0]        chosen_idx;
   logic                             same_run;
   logic                             rose;
   logic [ppr_pkg::QUANTUM_W-1:0]    run_in;
   logic [ppr_pkg::BURST_W-1:0]      rem_next;
   logic                             fin;
   logic                             rotate;
   logic                             rsp_free;

   ppr_ram #(
      .WIDTH (ppr_pkg::ENTRY_W),
      .DEPTH (ppr_pkg::MAX_PROCESSES)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_entry),
      .rd_addr (rd_addr),
      .rd_data (rd_entry)
   );

   assign idx_dec   = idx_ff - 1'b1;
   assign count_dec = count_ff - 1'b1;
   assign rd_addr   = cmd.load_read ? idx_dec[ppr_pkg::IDX_W-1:0] : idx_ff[ppr_pkg::IDX_W-1:0];
   assign scan_more = idx_ff < count_ff;
   assign eligible  = (rd_entry.remaining != '0) && (rd_entry.arrival <= time_ff);

   // A process strictly above the tracked level wins over one at the level.
   assign found      = found1_ff || found2_ff;
   assign chosen     = found1_ff ? cand1_ff : cand2_ff;
   assign chosen_idx = found1_ff ? cand1_idx_ff : cand2_idx_ff;

   always_comb begin
      same_run = last_valid_ff && (last_id_ff == chosen.id);
      rose     = 1'b1;
      run_in   = run_ff;
      if (!same_run) begin
         run_in = 8'd1;
      end else if (run_ff != '1) begin
         run_in = run_ff + 1'b1;
      end else begin
         rose = 1'b0;
      end
   end

   assign rem_next = chosen.remaining - 1'b1;
   assign fin      = (rem_next == '0);
   // Unless it finishes, the chosen process sits at the level that is tracked after the tick,
   // so only the run count and the remaining burst decide the rotation.
   assign rotate   = found && rose && (run_in == quantum_ff) && !fin;
   assign rsp_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      new_entry.arrival        = req_ff.arrival_time;
      new_entry.remaining      = req_ff.burst_length;
      new_entry.priority_level = req_ff.priority_level;
      new_entry.id             = ppr_pkg::pid_of(count_ff);
      updated_entry            = chosen;
      updated_entry.remaining  = rem_next;
   end

   always_comb begin
      wr_en    = 1'b0;
      wr_addr  = idx_ff[ppr_pkg::IDX_W-1:0];
      wr_entry = rd_entry;
      if (cmd.load_shift) begin
         wr_en = 1'b1;
      end else if (cmd.load_insert) begin
         wr_en    = 1'b1;
         wr_entry = new_entry;
      end else if (cmd.update && found && !rotate) begin
         wr_en    = 1'b1;
         wr_addr  = chosen_idx;
         wr_entry = updated_entry;
      end else if (cmd.rot_step) begin
         if (cmp_valid_ff) begin
            wr_en   = 1'b1;
            wr_addr = cmp_idx_ff - 1'b1;
         end else if (!scan_more) begin
            // Shifting is over; the rotated process lands at the table end.
            wr_en    = 1'b1;
            wr_addr  = count_dec[ppr_pkg::IDX_W-1:0];
            wr_entry = held_ff;
         end
      end
   end

   always_comb begin
      stat.table_full = (count_ff == ppr_pkg::FULL_COUNT);
      stat.pos_zero   = (idx_ff == '0);
      stat.load_stop  = (rd_entry.arrival <= req_ff.arrival_time);
      stat.scan_done  = !scan_more && !cmp_valid_ff;
      stat.rotate     = rotate;
      stat.rot_done   = !scan_more && !cmp_valid_ff;
      stat.rsp_free   = rsp_free;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         pending_ff    <= '0;
         idx_ff        <= '0;
         cmp_idx_ff    <= '0;
         cmp_valid_ff  <= 1'b0;
         time_ff       <= '0;
         tracked_ff    <= '0;
         last_id_ff    <= '0;
         last_valid_ff <= 1'b0;
         run_ff        <= '0;
         quantum_ff    <= 8'd1;
         found1_ff     <= 1'b0;
         found2_ff     <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_valid) begin
            quantum_ff <= csr_quantum;
         end
         if (cmd.finish) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (cmd.accept) begin
            found1_ff    <= 1'b0;
            found2_ff    <= 1'b0;
            cmp_valid_ff <= 1'b0;
            idx_ff       <= (req_in.operation == ppr_pkg::OP_LOAD) ? count_ff : '0;
            if (req_in.operation == ppr_pkg::OP_CLEAR) begin
               count_ff      <= '0;
               pending_ff    <= '0;
               time_ff       <= '0;
               tracked_ff    <= '0;
               last_id_ff    <= '0;
               last_valid_ff <= 1'b0;
               run_ff        <= '0;
            end
         end
         if (cmd.load_shift) begin
            idx_ff <= idx_dec;
         end
         if (cmd.load_insert) begin
            count_ff <= count_ff + 1'b1;
            if (req_ff.burst_length != '0) begin
               pending_ff <= pending_ff + 1'b1;
            end
         end
         // Scan and rotation share one read pointer; the table read is registered.
         if (cmd.scan_step || cmd.rot_step) begin
            if (scan_more) begin
               idx_ff       <= idx_ff + 1'b1;
               cmp_idx_ff   <= idx_ff[ppr_pkg::IDX_W-1:0];
               cmp_valid_ff <= 1'b1;
            end else begin
               cmp_valid_ff <= 1'b0;
            end
         end
         if (cmd.scan_step && cmp_valid_ff && eligible) begin
            if (rd_entry.priority_level > best_level_ff) begin
               found1_ff <= 1'b1;
            end
            if ((rd_entry.priority_level == tracked_ff) && !found2_ff) begin
               found2_ff <= 1'b1;
            end
         end
         if (cmd.update) begin
            tracked_ff <= (found && fin) ? '0 : best_level_ff;
            if (time_ff != '1) begin
               time_ff <= time_ff + 1'b1;
            end
            if (found) begin
               run_ff        <= run_in;
               last_id_ff    <= chosen.id;
               last_valid_ff <= 1'b1;
               if (fin) begin
                  pending_ff <= pending_ff - 1'b1;
               end
               if (rotate) begin
                  idx_ff       <= ppr_pkg::next_index(chosen_idx);
                  cmp_valid_ff <= 1'b0;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         req_ff            <= req_in;
         best_level_ff     <= tracked_ff;
         res_ff.time_now   <= time_ff;
         res_ff.process_id <= '0;
         res_ff.finished   <= 1'b0;
         res_ff.all_done   <= 1'b0;
         res_ff.status     <= (req_in.operation == ppr_pkg::OP_CLEAR) ?
                              ppr_pkg::ST_CLEARED : ppr_pkg::ST_REJECTED;
      end
      if (cmd.load_insert) begin
         res_ff.status     <= ppr_pkg::ST_LOADED;
         res_ff.process_id <= ppr_pkg::pid_of(count_ff);
      end
      if (cmd.scan_step && cmp_valid_ff && eligible) begin
         if (rd_entry.priority_level > best_level_ff) begin
            best_level_ff <= rd_entry.priority_level;
            cand1_ff      <= rd_entry;
            cand1_idx_ff  <= cmp_idx_ff;
         end
         if ((rd_entry.priority_level == tracked_ff) && !found2_ff) begin
            cand2_ff     <= rd_entry;
            cand2_idx_ff <= cmp_idx_ff;
         end
      end
      if (cmd.update) begin
         held_ff <= updated_entry;
         if (found) begin
            res_ff.status     <= ppr_pkg::ST_RAN;
            res_ff.process_id <= chosen.id;
            res_ff.finished   <= fin;
         end else begin
            res_ff.status <= ppr_pkg::ST_IDLE;
         end
      end
      if (cmd.finish) begin
         rsp_ff <= {res_ff.status, res_ff.process_id, res_ff.finished, res_ff.time_now,
                    pending_ff == '0};
      end
   end

   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_out   = rsp_ff;

   `PPR_ASSERT_NEVER(a_count_bound, clock, reset, count_ff > ppr_pkg::FULL_COUNT)
   `PPR_ASSERT_NEVER(a_pending_bound, clock, reset, pending_ff > count_ff)
   `PPR_ASSERT(a_finish_space, clock, reset, cmd.finish |-> rsp_free)
   `PPR_ASSERT(a_insert_room, clock, reset, cmd.load_insert |-> !stat.table_full)
   `PPR_ASSERT(a_finish_level, clock, reset, (cmd.update && found && fin) |=> (tracked_ff == '0))

endmodule
